// ===== rtl/wsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants for the websocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

    // frame opcodes that carry data to the output
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;

    // length codes in the second header byte that announce an extended length
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // extended length and mask key byte counts, minus one
    localparam logic [2:0] EXT16_BYTES_M1 = 3'd1;
    localparam logic [2:0] EXT64_BYTES_M1 = 3'd7;
    localparam logic [2:0] KEY_BYTES_M1   = 3'd3;

    // parser phase
    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    // one registered input item
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_byte_item;

    // one result item
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       is_text;
        logic       last_of_frame;
        logic       empty_frame;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/wsd_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_in_stage
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module wsd_in_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [7:0]        i_data_byte,
    output logic                   o_stall,
    input  wire logic              i_adv,
    output wsd_pkg::t_byte_item    o_item
);

    logic       r_valid;
    logic [7:0] r_data;

    // hold off the sender while a byte sits here and the pipe cannot move
    assign o_stall = r_valid & ~i_adv;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    // byte capture
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_data <= i_data_byte;
        end
    end

    assign o_item.valid = r_valid;
    assign o_item.data  = r_data;

endmodule
`default_nettype wire

// ===== rtl/wsd_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header parser, length counter and payload unmasking.
// ----------------------------------------------------------------------------
module wsd_parser (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire wsd_pkg::t_byte_item i_item,
    input  wire logic              i_adv,
    output logic                   o_emit,
    output wsd_pkg::t_result       o_result
);

    wsd_pkg::t_phase r_phase, n_phase;
    logic [3:0]      r_opcode, n_opcode;
    logic            r_mask_present, n_mask_present;
    logic [63:0]     r_rem, n_rem;
    logic [2:0]      r_hdr_left, n_hdr_left;
    logic [31:0]     r_key, n_key;
    logic [1:0]      r_mask_idx, n_mask_idx;

    logic            step;
    logic [7:0]      b;
    logic            data_frame;
    logic            hdr_done;
    logic [63:0]     hdr_len;
    logic [7:0]      key_byte;

    assign step       = i_item.valid & i_adv;
    assign b          = i_item.data;
    assign data_frame = (r_opcode == wsd_pkg::OP_TEXT) || (r_opcode == wsd_pkg::OP_BINARY);

    // key byte for the next payload byte, first key byte first
    always_comb begin
        case (r_mask_idx)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= wsd_pkg::PH_HDR0;
            r_opcode       <= 4'h0;
            r_mask_present <= 1'b0;
            r_rem          <= 64'd0;
            r_hdr_left     <= 3'd0;
            r_key          <= 32'd0;
            r_mask_idx     <= 2'd0;
        end else begin
            r_phase        <= n_phase;
            r_opcode       <= n_opcode;
            r_mask_present <= n_mask_present;
            r_rem          <= n_rem;
            r_hdr_left     <= n_hdr_left;
            r_key          <= n_key;
            r_mask_idx     <= n_mask_idx;
        end
    end

    // next state and result
    always_comb begin
        n_phase        = r_phase;
        n_opcode       = r_opcode;
        n_mask_present = r_mask_present;
        n_rem          = r_rem;
        n_hdr_left     = r_hdr_left;
        n_key          = r_key;
        n_mask_idx     = r_mask_idx;
        hdr_done       = 1'b0;
        hdr_len        = r_rem;
        o_emit         = 1'b0;
        o_result       = '0;

        if (step) begin
            unique case (r_phase)
                wsd_pkg::PH_HDR1: begin
                    n_mask_present = b[7];
                    n_rem          = 64'd0;
                    if (b[6:0] == wsd_pkg::LEN_EXT16) begin
                        n_hdr_left = wsd_pkg::EXT16_BYTES_M1;
                        n_phase    = wsd_pkg::PH_EXTLEN;
                    end else if (b[6:0] == wsd_pkg::LEN_EXT64) begin
                        n_hdr_left = wsd_pkg::EXT64_BYTES_M1;
                        n_phase    = wsd_pkg::PH_EXTLEN;
                    end else begin
                        n_rem = {57'd0, b[6:0]};
                        if (b[7]) begin
                            n_key      = 32'd0;
                            n_hdr_left = wsd_pkg::KEY_BYTES_M1;
                            n_phase    = wsd_pkg::PH_MASK;
                        end else begin
                            hdr_done = 1'b1;
                            hdr_len  = n_rem;
                        end
                    end
                end
                wsd_pkg::PH_EXTLEN: begin
                    n_rem = {r_rem[55:0], b};
                    if (r_hdr_left == 3'd0) begin
                        if (r_mask_present) begin
                            n_key      = 32'd0;
                            n_hdr_left = wsd_pkg::KEY_BYTES_M1;
                            n_phase    = wsd_pkg::PH_MASK;
                        end else begin
                            hdr_done = 1'b1;
                            hdr_len  = n_rem;
                        end
                    end else begin
                        n_hdr_left = r_hdr_left - 3'd1;
                    end
                end
                wsd_pkg::PH_MASK: begin
                    n_key = {r_key[23:0], b};
                    if (r_hdr_left == 3'd0) begin
                        hdr_done = 1'b1;
                        hdr_len  = r_rem;
                    end else begin
                        n_hdr_left = r_hdr_left - 3'd1;
                    end
                end
                wsd_pkg::PH_PAYLOAD: begin
                    n_mask_idx = r_mask_idx + 2'd1;
                    n_rem      = r_rem - 64'd1;
                    if (r_rem == 64'd1) begin
                        n_phase = wsd_pkg::PH_HDR0;
                    end
                    if (data_frame) begin
                        o_emit                 = 1'b1;
                        o_result.payload_byte  = r_mask_present ? (b ^ key_byte) : b;
                        o_result.is_text       = (r_opcode == wsd_pkg::OP_TEXT);
                        o_result.last_of_frame = (r_rem == 64'd1);
                        o_result.empty_frame   = 1'b0;
                    end
                end
                default: begin
                    // first header byte, and unused phase codes
                    n_opcode = b[3:0];
                    n_phase  = wsd_pkg::PH_HDR1;
                end
            endcase

            // header complete: enter the payload or close an empty frame
            if (hdr_done) begin
                n_mask_idx = 2'd0;
                if (hdr_len == 64'd0) begin
                    n_phase = wsd_pkg::PH_HDR0;
                    if (data_frame) begin
                        o_emit                 = 1'b1;
                        o_result.payload_byte  = 8'd0;
                        o_result.is_text       = (r_opcode == wsd_pkg::OP_TEXT);
                        o_result.last_of_frame = 1'b1;
                        o_result.empty_frame   = 1'b1;
                    end
                end else begin
                    n_phase = wsd_pkg::PH_PAYLOAD;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/wsd_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_out_stage
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module wsd_out_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_emit,
    input  wire wsd_pkg::t_result  i_result,
    output logic                   o_adv,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [7:0]             o_payload_byte,
    output logic                   o_is_text,
    output logic                   o_last_of_frame,
    output logic                   o_empty_frame
);

    logic             r_valid;
    wsd_pkg::t_result r_result;

    // pipe moves when the register is empty or being taken
    assign o_adv = ~r_valid | ~i_stall;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_emit;
        end
    end

    // result capture
    always_ff @(posedge i_clk) begin
        if (o_adv && i_emit) begin
            r_result <= i_result;
        end
    end

    assign o_valid         = r_valid;
    assign o_payload_byte  = r_result.payload_byte;
    assign o_is_text       = r_result.is_text;
    assign o_last_of_frame = r_result.last_of_frame;
    assign o_empty_frame   = r_result.empty_frame;

endmodule
`default_nettype wire

// ===== rtl/websocket_frame_deframer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Path: an accepted byte passes the input register, then the result register.
// Throughput: one byte per cycle while the receiver does not stall; the parser
// computes next state and result combinationally between the two registers.
// A stalled result item holds the result register and, when the input register
// holds a byte, holds it too and stalls the sender in the same cycle.
// Reset: synchronous, active low; clears the parser to expect a first header
// byte and empties both the input and result registers.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_data_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_payload_byte,
    output logic            o_is_text,
    output logic            o_last_of_frame,
    output logic            o_empty_frame
);

    wsd_pkg::t_byte_item item;
    wsd_pkg::t_result    result;
    logic                adv;
    logic                emit;

    // input register
    wsd_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .o_stall     (o_stall),
        .i_adv       (adv),
        .o_item      (item)
    );

    // header parsing and unmasking
    wsd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item),
        .i_adv    (adv),
        .o_emit   (emit),
        .o_result (result)
    );

    // result register
    wsd_out_stage u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_emit          (emit),
        .i_result        (result),
        .o_adv           (adv),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_payload_byte  (o_payload_byte),
        .o_is_text       (o_is_text),
        .o_last_of_frame (o_last_of_frame),
        .o_empty_frame   (o_empty_frame)
    );

endmodule
`default_nettype wire
